[rtl/size_sorted_record_list_unit_defines.svh]
// ------------------------------------------------------------------------
// size sorted record list assertion macros
// clocked property checks used by the list unit
// ------------------------------------------------------------------------
`ifndef SIZE_SORTED_RECORD_LIST_UNIT_DEFINES_SVH
`define SIZE_SORTED_RECORD_LIST_UNIT_DEFINES_SVH

// check that is switched off while reset is high
`define SSRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define SSRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ssrl_pkg.sv]
// ------------------------------------------------------------------------
// ssrl_pkg
// shared types and codes of the size sorted record list
// ------------------------------------------------------------------------
package ssrl_pkg;

  localparam int IdW   = 31;
  localparam int OffW  = 32;
  localparam int SizeW = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [OffW-1:0]  offset;
    logic [SizeW-1:0] size;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic   compare;   // latch compare flags against cmp_key
    logic   apply;     // perform the shift of this request
    logic   op;        // opcode of the request being applied
    entry_t cmp_key;   // request fields in the accept cycle
    entry_t new_entry; // registered request fields
  } cell_cmd_t;

endpackage

[rtl/ssrl_cell.sv]
// ------------------------------------------------------------------------
// ssrl_cell
// one slot of the sorted chain: compare flags and neighbor shift
// ------------------------------------------------------------------------
module ssrl_cell import ssrl_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      slot_valid,
  input  entry_t    prev_entry,
  input  logic      prev_keep,
  input  logic      prev_seen,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      keep,
  output logic      seen
);

  entry_t entry_r;
  logic   keep_r;
  logic   match_r;

  // first matching cell and everything behind it close the gap
  assign seen  = prev_seen | match_r;
  assign keep  = keep_r;
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      keep_r  <= slot_valid && (entry_r.size <= cmd.cmp_key.size);
      match_r <= slot_valid && (entry_r.id == cmd.cmp_key.id);
    end
    if (cmd.apply) begin
      if (cmd.op == OP_INSERT) begin
        if (!keep_r) begin
          entry_r <= prev_keep ? cmd.new_entry : prev_entry;
        end
      end else if (seen) begin
        entry_r <= next_entry;
      end
    end
  end

endmodule

[rtl/size_sorted_record_list_unit.sv]
// ------------------------------------------------------------------------
// size_sorted_record_list_unit
// table of records kept in ascending size order, insert and remove by id
// ------------------------------------------------------------------------
//
//  channel   handshake          payload
//  request   start / busy       opcode, record_id, byte_offset, record_size
//  result    done (one cycle)   status, entry_count, head_valid, head_id,
//                               head_offset, head_size
//
//  in the accept cycle every cell compares its slot with the request, in
//  the next cycle (busy high) the chain shifts one place toward or away from
//  the insert or remove point, unless an insert finds the table full or a
//  remove finds no match; the result strobes in the cycle after the shift,
//  while the next request may already be accepted; none is taken while busy
//  synchronous reset empties the table at once; slot contents need none
//  the receiver cannot stall: each result is shown for exactly one cycle
//
`include "size_sorted_record_list_unit_defines.svh"

module size_sorted_record_list_unit import ssrl_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CntW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             opcode,
  input  logic [IdW-1:0]   record_id,
  input  logic [OffW-1:0]  byte_offset,
  input  logic [SizeW-1:0] record_size,
  output logic             done,
  output logic [1:0]       status,
  output logic [CntW-1:0]  entry_count,
  output logic             head_valid,
  output logic [IdW-1:0]   head_id,
  output logic [OffW-1:0]  head_offset,
  output logic [SizeW-1:0] head_size
);

  // control state
  logic            pend;
  logic            done_r;
  logic [CntW-1:0] held_count;
  logic [CntW-1:0] held_count_next;
  status_t         status_r;
  status_t         status_next;

  // registered request
  logic   op_r;
  entry_t item_r;

  // chain signals
  cell_cmd_t cmd;
  entry_t    cell_entry [CAPACITY];
  logic      cell_keep  [CAPACITY];
  logic      cell_seen  [CAPACITY];

  logic accept;
  logic full;
  logic found;
  logic apply_ok;

  assign accept = start && !busy;
  assign busy   = pend;
  assign full   = (held_count == CntW'(CAPACITY));
  // prefix of id matches reaches the end of the chain only if any cell hit
  assign found  = cell_seen[CAPACITY-1];

  assign apply_ok = (op_r == OP_INSERT) ? !full : found;

  assign cmd.compare           = accept;
  assign cmd.apply             = pend && apply_ok;
  assign cmd.op                = op_r;
  assign cmd.cmp_key.id        = record_id;
  assign cmd.cmp_key.offset    = byte_offset;
  assign cmd.cmp_key.size      = record_size;
  assign cmd.new_entry         = item_r;

  // count and status of the request in flight
  always_comb begin
    held_count_next = held_count;
    status_next     = ST_OK;
    if (op_r == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        held_count_next = held_count + CntW'(1);
      end
    end else begin
      if (found) begin
        held_count_next = held_count - CntW'(1);
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      done_r     <= 1'b0;
      held_count <= '0;
    end else begin
      pend   <= accept;
      done_r <= pend;
      if (pend) begin
        held_count <= held_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= opcode;
      item_r.id     <= record_id;
      item_r.offset <= byte_offset;
      item_r.size   <= record_size;
    end
    if (pend) begin
      status_r <= status_next;
    end
  end

  // row of slots; slot 0 is the head, a new entry is written straight into its sorted slot
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_keep;
    logic   prev_seen;
    entry_t next_entry;
    logic   slot_valid;

    // occupied slots are exactly the first held_count ones
    assign slot_valid = (CntW'(i) < held_count);

    if (i == 0) begin : g_first
      assign prev_entry = item_r;
      assign prev_keep  = 1'b1;
      assign prev_seen  = 1'b0;
    end else begin : g_inner
      assign prev_entry = cell_entry[i-1];
      assign prev_keep  = cell_keep[i-1];
      assign prev_seen  = cell_seen[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // the slot past the end is never valid, any content will do
      assign next_entry = cell_entry[i];
    end else begin : g_mid
      assign next_entry = cell_entry[i+1];
    end

    ssrl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot_valid (slot_valid),
      .prev_entry (prev_entry),
      .prev_keep  (prev_keep),
      .prev_seen  (prev_seen),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .keep       (cell_keep[i]),
      .seen       (cell_seen[i])
    );
  end

  // result: head comes straight from slot 0, which holds until the next shift
  assign done        = done_r;
  assign status      = status_r;
  assign entry_count = held_count;
  assign head_valid  = (held_count != '0);
  assign head_id     = head_valid ? cell_entry[0].id     : '0;
  assign head_offset = head_valid ? cell_entry[0].offset : '0;
  assign head_size   = head_valid ? cell_entry[0].size   : '0;

  // checks
  `SSRL_ASSERT(a_count_bound, held_count <= CntW'(CAPACITY),
    "entry count above capacity")
  `SSRL_ASSERT(a_done_after_apply, pend |=> done, "result missing after shift")
  `SSRL_ASSERT(a_no_overlap, !(pend && done), "shift and result overlap")
  `SSRL_ASSERT(a_full_status, (done && status == ST_FULL) |-> full,
    "full status with room left")

endmodule

[sim/tb_size_sorted_record_list_unit.sv]
// ------------------------------------------------------------------------
// tb_size_sorted_record_list_unit
// self-checking bench for the size sorted record list: a directed table of
// requests then random insert/remove traffic; a typed row's result is held
// to its own values, all others to a behavioral copy of the size ordered table
// ------------------------------------------------------------------------
module tb_size_sorted_record_list_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import ssrl_pkg::*;

  localparam int CAP             = 16;
  localparam int CntW            = $clog2(CAP + 1);
  localparam int RANDOM_REQUESTS = 1250;
  localparam int STALL_LIMIT     = 1000;  // cycles with nothing moving
  localparam int DRAIN_LIMIT     = 200;   // cycles to wait for the last results
  localparam int TAIL_CYCLES     = 4;     // settle time after the drain loop

  // one result as the block reports it
  typedef struct packed {
    status_t         status;
    logic [CntW-1:0] count;
    logic            head_valid;
    entry_t          head;
  } list_result_t;

  // one request of the stimulus; a typed row carries its result spelled out
  typedef struct {
    logic             op;
    logic [IdW-1:0]   id;
    logic [OffW-1:0]  off;
    logic [SizeW-1:0] size;
    bit               typed;
    list_result_t     want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             opcode;
  logic [IdW-1:0]   record_id;
  logic [OffW-1:0]  byte_offset;
  logic [SizeW-1:0] record_size;
  logic             done;
  logic [1:0]       status;
  logic [CntW-1:0]  entry_count;
  logic             head_valid;
  logic [IdW-1:0]   head_id;
  logic [OffW-1:0]  head_offset;
  logic [SizeW-1:0] head_size;

  size_sorted_record_list_unit #(
    .CAPACITY(CAP)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .record_id  (record_id),
    .byte_offset(byte_offset),
    .record_size(record_size),
    .done       (done),
    .status     (status),
    .entry_count(entry_count),
    .head_valid (head_valid),
    .head_id    (head_id),
    .head_offset(head_offset),
    .head_size  (head_size)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // predictor state: the table kept in ascending size order, ties in
  // arrival order, exactly as the block should hold it
  // ------------------------------------------------------------------
  entry_t       sorted_entries[$];
  list_result_t pending_results[$];  // predicted results not yet reported
  stim_row_t    directed_rows[$];

  // typed expectation of the request now on the ports
  bit           req_typed;
  list_result_t req_want;

  int errors;
  int burst_left;
  int stall_cycles;
  int n_insert, n_remove, n_full, n_miss, n_checked, peak_count;

  function automatic entry_t mk_entry(logic [IdW-1:0] id, logic [OffW-1:0] off,
                                      logic [SizeW-1:0] size);
    entry_t e;
    e.id     = id;
    e.offset = off;
    e.size   = size;
    return e;
  endfunction

  // apply one request to the predicted table and return the result it causes
  function automatic list_result_t update_size_list(logic op, logic [IdW-1:0] id,
                                                    logic [OffW-1:0] off,
                                                    logic [SizeW-1:0] size);
    list_result_t r;
    int pos;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      n_insert++;
      if (sorted_entries.size() >= CAP) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of smaller or equal size
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].size <= size) pos++;
        sorted_entries.insert(pos, mk_entry(id, off, size));
      end
    end else begin
      n_remove++;
      pos = 0;
      while (pos < sorted_entries.size() && sorted_entries[pos].id != id) pos++;
      if (pos >= sorted_entries.size()) r.status = ST_NOT_FOUND;
      else sorted_entries.delete(pos);
    end
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_NOT_FOUND) n_miss++;
    r.count = CntW'(sorted_entries.size());
    if (sorted_entries.size() > peak_count) peak_count = sorted_entries.size();
    // empty table shows an all-zero head
    r.head_valid = (sorted_entries.size() != 0);
    r.head       = r.head_valid ? sorted_entries[0] : '0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // ------------------------------------------------------------------
  // monitor: predict on each accepted request, check each strobed result
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst) begin
      // the result of this edge belongs to an older request, so check first
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding, got status %0h count %0d",
                   $time, status, entry_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("entry_count", 64'(want.count), 64'(entry_count));
          check_field("head_valid", 64'(want.head_valid), 64'(head_valid));
          check_field("head_id", 64'(want.head.id), 64'(head_id));
          check_field("head_offset", 64'(want.head.offset), 64'(head_offset));
          check_field("head_size", 64'(want.head.size), 64'(head_size));
          n_checked++;
        end
      end
      if (start && !busy) begin
        // predictor always advances; a typed row overrides its expectation
        got = update_size_list(opcode, record_id, byte_offset, record_size);
        pending_results.push_back(req_typed ? req_want : got);
      end
    end
  end

  // watchdog: give up when no request is accepted and no result strobes for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  task automatic add_row(logic op, logic [IdW-1:0] id, logic [OffW-1:0] off,
                         logic [SizeW-1:0] size);
    stim_row_t r;
    r.op    = op;
    r.id    = id;
    r.off   = off;
    r.size  = size;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_typed(logic op, logic [IdW-1:0] id, logic [OffW-1:0] off,
                           logic [SizeW-1:0] size, status_t st, int cnt, entry_t head);
    stim_row_t r;
    r.op              = op;
    r.id              = id;
    r.off             = off;
    r.size            = size;
    r.typed           = 1'b1;
    r.want.status     = st;
    r.want.count      = CntW'(cnt);
    r.want.head_valid = (cnt != 0);
    r.want.head       = head;
    directed_rows.push_back(r);
  endtask

  // random request; insert_pct steers the table toward full or empty
  function automatic stim_row_t random_request(int insert_pct);
    stim_row_t r;
    int pick;
    int held;
    held    = sorted_entries.size();
    r.typed = 1'b0;
    r.want  = '0;
    r.op    = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    r.off   = $urandom;
    r.size  = SizeW'($urandom);  // don't care on remove, still toggled
    pick    = $urandom_range(0, 99);
    if (r.op == OP_INSERT) begin
      // small id pool gives duplicate ids
      if (pick < 65) r.id = IdW'($urandom_range(0, 15));
      else if (pick < 85 && held != 0) r.id = sorted_entries[$urandom_range(0, held - 1)].id;
      else if (pick < 90) r.id = '1;
      else r.id = IdW'($urandom);
      pick = $urandom_range(0, 99);
      // narrow sizes give ties, wide ones hit every bit
      if (pick < 40) r.size = SizeW'($urandom_range(0, 7));
      else if (pick < 50) r.size = '0;
      else if (pick < 60) r.size = '1;
      else if (pick < 70 && held != 0) r.size = sorted_entries[$urandom_range(0, held - 1)].size;
    end else begin
      // mostly remove something held, sometimes the head, sometimes a miss
      if (pick < 60 && held != 0) r.id = sorted_entries[$urandom_range(0, held - 1)].id;
      else if (pick < 70 && held != 0) r.id = sorted_entries[0].id;
      else if (pick < 90) r.id = IdW'($urandom_range(0, 15));
      else r.id = IdW'($urandom);
    end
    return r;
  endfunction

  // present one request, with a random gap at the start of each burst,
  // and hold it until the block takes it
  task automatic send_request(input stim_row_t r);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      repeat (idle) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start       = 1'b1;
    opcode      = r.op;
    record_id   = r.id;
    byte_offset = r.off;
    record_size = r.size;
    req_typed   = r.typed;
    req_want    = r.want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    int insert_pct;
    int guard;
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_INSERT;
    record_id    = '0;
    byte_offset  = '0;
    record_size  = '0;
    req_typed    = 1'b0;
    req_want     = '0;
    errors       = 0;
    burst_left   = 0;
    n_insert     = 0;
    n_remove     = 0;
    n_full       = 0;
    n_miss       = 0;
    n_checked    = 0;
    peak_count   = 0;
    insert_pct   = 50;

    // remove from the empty table misses and the head reads as zeros
    add_typed(OP_REMOVE, 31'd5, '1, '1, ST_NOT_FOUND, 0, '0);
    // all-ones fields
    add_typed(OP_INSERT, '1, '1, '1, ST_OK, 1, mk_entry('1, '1, '1));
    // all-zero fields, new head
    add_typed(OP_INSERT, '0, '0, '0, ST_OK, 2, mk_entry('0, '0, '0));
    // equal size lands behind the older entry, head unchanged
    add_typed(OP_INSERT, 31'd1, 32'h1234_5678, '0, ST_OK, 3, mk_entry('0, '0, '0));
    // removing the head lowers the count and promotes the tie
    add_typed(OP_REMOVE, '0, 32'hDEAD_BEEF, 16'h00AA, ST_OK, 2,
              mk_entry(31'd1, 32'h1234_5678, '0));
    // same id again is gone now
    add_typed(OP_REMOVE, '0, '0, '0, ST_NOT_FOUND, 2, mk_entry(31'd1, 32'h1234_5678, '0));
    // two entries sharing one id
    add_row(OP_INSERT, 31'd7, 32'hA5A5_0001, 16'd300);
    add_row(OP_INSERT, 31'd7, 32'hA5A5_0002, 16'd200);
    // fill to capacity
    for (int k = 0; k < CAP - 4; k++) add_row(OP_INSERT, 31'(100 + k), $urandom, 16'(k * 5461));
    // insert into the full table is refused
    add_typed(OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555, 16'd1, ST_FULL, CAP,
              mk_entry(31'd1, 32'h1234_5678, '0));
    // duplicate id: the one first in size order goes
    add_row(OP_REMOVE, 31'd7, $urandom, SizeW'($urandom));
    // tail entry, then the head
    add_row(OP_REMOVE, '1, '0, '0);
    add_row(OP_REMOVE, 31'd1, '1, '1);

    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // random traffic in segments that lean toward filling or draining
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) insert_pct = $urandom_range(15, 90);
      send_request(random_request(insert_pct));
    end

    @(negedge clk);
    start = 1'b0;

    // let the outstanding results come back
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d predicted results never reported", $time, pending_results.size());
      errors += pending_results.size();
    end

    $display("requests: %0d inserts (%0d refused as full), %0d removes (%0d misses)",
             n_insert, n_full, n_remove, n_miss);
    $display("results checked: %0d, peak table fill %0d of %0d, errors %0d",
             n_checked, peak_count, CAP, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
